// ===== hdl/tpid_pkg.sv =====
// Shared types and constants for the tiled palette icon decoder.
// No dependencies; every other file in hdl/ imports this package.
package tpid_pkg;

    // Stream field widths
    localparam int ICON_BYTE_W = 8;
    localparam int COUNT_W     = 9;
    localparam int ADDR_W      = 11;
    localparam int CHAN_W      = 8;
    localparam int INDEX_W     = 4;
    localparam int COLOR_W     = 15;
    localparam int OUT_DATA_W  = 80;   // 75 bits of fields, padded to whole bytes

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int PALETTE_W   = 4 * CFG_DATA_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_PAL_0_TO_3   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAL_4_TO_7   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAL_8_TO_11  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAL_12_TO_15 = 2'd3;

    // Last byte of one icon
    localparam logic [COUNT_W-1:0] LAST_BYTE = 9'd511;

    localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'd0;
    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;

    // floor(c * 255 / 31) for a 5-bit channel
    localparam logic [CHAN_W-1:0] EXPAND5_LUT [32] = '{
        8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
        8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
        8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
        8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
    };

    typedef struct packed {
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } pixel_rgba_t;

endpackage

// ===== hdl/tpid_byte_counter.sv =====
// Byte position counter for the icon stream.
// Depends on tpid_pkg for widths.
module tpid_byte_counter
    import tpid_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               restart,
    output logic [COUNT_W-1:0] position
);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    // A restart forces position zero for the current item
    assign position   = restart ? '0 : count_reg;
    assign count_next = position + COUNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (advance)
        begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== hdl/tpid_texel_addr.sv =====
// Untiles a byte position into a texel address of the left pixel.
// Depends on tpid_pkg for widths.
module tpid_texel_addr
    import tpid_pkg::*;
#(
    parameter int TEXTURE_ROW_PITCH = 64
)
(
    input  logic [COUNT_W-1:0] position,
    output logic [ADDR_W-1:0]  texel_address
);

    localparam int PITCH_W = $clog2(TEXTURE_ROW_PITCH + 1);
    localparam int PROD_W  = 5 + PITCH_W;

    logic [4:0]        pixel_x;
    logic [4:0]        pixel_row;
    logic [PROD_W-1:0] row_offset;

    // x = tile column * 8 + pair * 2; row = tile row * 8 + row in tile
    assign pixel_x    = {position[6:5], position[1:0], 1'b0};
    assign pixel_row  = {position[8:7], position[4:2]};
    assign row_offset = PROD_W'(pixel_row) * PROD_W'(TEXTURE_ROW_PITCH);

    // Address wraps at 2048
    assign texel_address = row_offset[ADDR_W-1:0] + ADDR_W'(pixel_x);

endmodule

// ===== hdl/tpid_palette_lookup.sv =====
// Palette registers and the two color lookups with channel expansion.
// Depends on tpid_pkg for register codes, the expansion table and pixel_rgba_t.
module tpid_palette_lookup
    import tpid_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [INDEX_W-1:0]     left_index,
    input  logic [INDEX_W-1:0]     right_index,
    output pixel_rgba_t            left_pixel,
    output pixel_rgba_t            right_pixel
);

    logic [PALETTE_W-1:0] palette_reg;
    logic [PALETTE_W-1:0] palette_next;
    logic [COLOR_W-1:0]   left_color;
    logic [COLOR_W-1:0]   right_color;

    // Register write decode
    always_comb
    begin
        palette_next = palette_reg;
        case (cfg_index)
            CFG_PAL_0_TO_3:   palette_next[63:0]    = cfg_data;
            CFG_PAL_4_TO_7:   palette_next[127:64]  = cfg_data;
            CFG_PAL_8_TO_11:  palette_next[191:128] = cfg_data;
            CFG_PAL_12_TO_15: palette_next[255:192] = cfg_data;
            default:          palette_next = palette_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_reg <= '0;
        end
        else if (cfg_write)
        begin
            palette_reg <= palette_next;
        end
    end

    // 16-bit entries, bit 15 unused
    assign left_color  = palette_reg[{left_index, 4'b0000} +: COLOR_W];
    assign right_color = palette_reg[{right_index, 4'b0000} +: COLOR_W];

    // Channel expansion; index zero is transparent
    always_comb
    begin
        left_pixel.red    = EXPAND5_LUT[left_color[4:0]];
        left_pixel.green  = EXPAND5_LUT[left_color[9:5]];
        left_pixel.blue   = EXPAND5_LUT[left_color[14:10]];
        left_pixel.alpha  = (left_index == '0) ? ALPHA_CLEAR : ALPHA_OPAQUE;
        right_pixel.red   = EXPAND5_LUT[right_color[4:0]];
        right_pixel.green = EXPAND5_LUT[right_color[9:5]];
        right_pixel.blue  = EXPAND5_LUT[right_color[14:10]];
        right_pixel.alpha = (right_index == '0) ? ALPHA_CLEAR : ALPHA_OPAQUE;
    end

endmodule

// ===== hdl/tiled_palette_icon_decoder_core.sv =====
// Top level of the tiled 4bpp palette icon decoder: input and result registers.
// Depends on tpid_pkg, tpid_byte_counter, tpid_texel_addr and tpid_palette_lookup.
//
//  Channel  Handshake                  Payload
//  -------  -------------------------  ------------------------------------------
//  s_axis   s_axis_tvalid/tready       tdata: icon_byte; tuser: start_of_icon
//  m_axis   m_axis_tvalid/tready       tdata: address and two RGBA pixels;
//                                      tlast: icon_done
//  cfg      cfg_valid/cfg_ready        cfg_index, cfg_data (palette words)
//
// One item per cycle sustained while m_axis_tready stays high; each item passes the
// input register, then the result register.
// cfg_ready is always high; palette registers reset to zero, counter to zero.
// A stalled result holds while the input register still takes one more item.
module tiled_palette_icon_decoder_core
    import tpid_pkg::*;
#(
    parameter int TEXTURE_ROW_PITCH = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // tdata [7:0] icon_byte
    input  logic [7:0]             s_axis_tdata,
    // tuser [0] start_of_icon
    input  logic                   s_axis_tuser,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata [10:0] texel_address, [18:11] left_red, [26:19] left_green,
    // [34:27] left_blue, [42:35] left_alpha, [50:43] right_red,
    // [58:51] right_green, [66:59] right_blue, [74:67] right_alpha, [79:75] zero
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    // tlast: icon_done
    output logic                   m_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic                   in_accept;
    logic                   out_load;
    logic [COUNT_W-1:0]     position;

    logic                   stage_valid_reg;
    logic [ICON_BYTE_W-1:0] stage_byte_reg;
    logic [COUNT_W-1:0]     stage_pos_reg;

    logic [ADDR_W-1:0]      texel_address;
    pixel_rgba_t            left_pixel;
    pixel_rgba_t            right_pixel;
    logic [OUT_DATA_W-1:0]  result_next;

    logic                   out_valid_reg;
    logic [OUT_DATA_W-1:0]  out_data_reg;
    logic                   out_last_reg;

    assign cfg_ready = 1'b1;

    // Flow control: result register frees, then the input register moves on
    assign out_load      = stage_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !stage_valid_reg || out_load;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    tpid_byte_counter u_counter (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (in_accept),
        .restart  (s_axis_tuser),
        .position (position)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            stage_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            stage_byte_reg <= s_axis_tdata;
            stage_pos_reg  <= position;
        end
    end

    tpid_texel_addr #(
        .TEXTURE_ROW_PITCH (TEXTURE_ROW_PITCH)
    ) u_addr (
        .position      (stage_pos_reg),
        .texel_address (texel_address)
    );

    tpid_palette_lookup u_palette (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .left_index  (stage_byte_reg[3:0]),
        .right_index (stage_byte_reg[7:4]),
        .left_pixel  (left_pixel),
        .right_pixel (right_pixel)
    );

    // Pack the result item
    assign result_next = {5'b00000,
                          right_pixel.alpha, right_pixel.blue,
                          right_pixel.green, right_pixel.red,
                          left_pixel.alpha, left_pixel.blue,
                          left_pixel.green, left_pixel.red,
                          texel_address};

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            out_valid_reg <= stage_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= result_next;
            out_last_reg <= (stage_pos_reg == LAST_BYTE);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== tb/sv/tb_tiled_palette_icon_decoder_core.sv =====
// Self-checking bench for tiled_palette_icon_decoder_core: random bursty stream in,
// random back-pressure out, every result compared against an in-bench decoder.
// Depends on tpid_pkg and the RTL in hdl/.
module tb_tiled_palette_icon_decoder_core;
    import tpid_pkg::*;

    localparam int ROW_PITCH         = 64;
    localparam int PIPE_LATENCY      = 2;
    localparam int LONG_STALL_CYCLES = 300;
    localparam int TIMEOUT_CYCLES    = 200000;

    // One decoded byte: address of the left texel and both pixels
    typedef struct {
        logic [ADDR_W-1:0] texel_address;
        pixel_rgba_t       left;
        pixel_rgba_t       right;
        logic              icon_done;
    } texel_pair_t;

    typedef struct {
        logic [ICON_BYTE_W-1:0] icon_byte;
        logic                   start_of_icon;
    } icon_item_t;

    typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_PATTERN, RX_SPARSE} rx_mode_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic [7:0]             s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;

    // Bench copy of the palette and the byte counter
    logic [CFG_DATA_W-1:0]  palette_copy [4];
    logic [COUNT_W-1:0]     icon_count;

    icon_item_t  pending_bytes [$];
    texel_pair_t expected_texels [$];

    int mismatch_count   = 0;
    int cycle_count      = 0;
    int burst_left       = 0;
    int gap_left         = 0;
    bit long_stall_req   = 1'b0;
    int long_stall_count = 0;
    rx_mode_t rx_mode    = RX_FREE;
    int rx_mode_left     = 0;
    logic [1:0] rx_tick  = '0;

    tiled_palette_icon_decoder_core #(
        .TEXTURE_ROW_PITCH (ROW_PITCH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > TIMEOUT_CYCLES)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // floor(c * 255 / 31)
    function automatic logic [CHAN_W-1:0] widen5(logic [4:0] c);
        int v;
        v = (int'(c) * 255) / 31;
        return v[CHAN_W-1:0];
    endfunction

    function automatic pixel_rgba_t palette_color(logic [INDEX_W-1:0] idx);
        logic [15:0] entry;
        pixel_rgba_t px;
        entry    = palette_copy[idx[3:2]][{idx[1:0], 4'b0000} +: 16];
        px.red   = widen5(entry[4:0]);
        px.green = widen5(entry[9:5]);
        px.blue  = widen5(entry[14:10]);
        px.alpha = (idx == '0) ? ALPHA_CLEAR : ALPHA_OPAQUE;
        return px;
    endfunction

    // Untile the counter and look up both pixels
    function automatic texel_pair_t decode_icon_byte(logic [COUNT_W-1:0] slot,
                                                     logic [ICON_BYTE_W-1:0] icon_byte);
        texel_pair_t r;
        logic [31:0] addr;
        addr = int'(slot[6:5]) * 8 + int'(slot[1:0]) * 2
             + (int'(slot[8:7]) * 8 + int'(slot[4:2])) * ROW_PITCH;
        r.texel_address = addr[ADDR_W-1:0];
        r.left          = palette_color(icon_byte[3:0]);
        r.right         = palette_color(icon_byte[7:4]);
        r.icon_done     = (slot == LAST_BYTE);
        return r;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Input driver: bursts of random length with random gaps
    always @(posedge clk)
    begin : byte_driver
        logic [COUNT_W-1:0] slot;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            icon_count = '0;
        end
        else
        begin
            // Item accepted at this edge: predict its result
            if (s_axis_tvalid && s_axis_tready)
            begin
                slot = s_axis_tuser ? '0 : icon_count;
                expected_texels.push_back(decode_icon_byte(slot, s_axis_tdata));
                icon_count = slot + 1'b1;
            end
            if (s_axis_tvalid && !s_axis_tready)
            begin
                // hold the offered item
            end
            else if (gap_left != 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_bytes.size() != 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_bytes[0].icon_byte;
                s_axis_tuser  <= pending_bytes[0].start_of_icon;
                void'(pending_bytes.pop_front());
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left--;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Result monitor and receiver back-pressure
    always @(posedge clk)
    begin : result_monitor
        texel_pair_t want;
        pixel_rgba_t got_left;
        pixel_rgba_t got_right;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_texels.size() == 0)
                begin
                    $error("result item with nothing expected, texel_address %0d",
                           m_axis_tdata[10:0]);
                    mismatch_count++;
                end
                else
                begin
                    want      = expected_texels.pop_front();
                    got_left  = m_axis_tdata[42:11];
                    got_right = m_axis_tdata[74:43];
                    check_field("texel_address", 32'(want.texel_address),
                                32'(m_axis_tdata[10:0]));
                    check_field("left_red", 32'(want.left.red), 32'(got_left.red));
                    check_field("left_green", 32'(want.left.green), 32'(got_left.green));
                    check_field("left_blue", 32'(want.left.blue), 32'(got_left.blue));
                    check_field("left_alpha", 32'(want.left.alpha), 32'(got_left.alpha));
                    check_field("right_red", 32'(want.right.red), 32'(got_right.red));
                    check_field("right_green", 32'(want.right.green),
                                32'(got_right.green));
                    check_field("right_blue", 32'(want.right.blue), 32'(got_right.blue));
                    check_field("right_alpha", 32'(want.right.alpha),
                                32'(got_right.alpha));
                    check_field("icon_done", 32'(want.icon_done), 32'(m_axis_tlast));
                    check_field("tdata_pad", 0, 32'(m_axis_tdata[79:75]));
                end
            end

            rx_tick <= rx_tick + 1'b1;
            if (long_stall_req && long_stall_count < LONG_STALL_CYCLES)
            begin
                // one long hold-off so the block fills and stalls its input
                long_stall_count++;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (rx_mode_left == 0)
                begin
                    rx_mode      = rx_mode_t'($urandom_range(0, 3));
                    rx_mode_left = $urandom_range(16, 96);
                end
                else
                    rx_mode_left--;
                case (rx_mode)
                    RX_FREE:    m_axis_tready <= 1'b1;
                    RX_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_PATTERN: m_axis_tready <= (rx_tick != 2'b11);
                    default:    m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic queue_item(logic [7:0] icon_byte, logic start_of_icon);
        icon_item_t it;
        it.icon_byte     = icon_byte;
        it.start_of_icon = start_of_icon;
        pending_bytes.push_back(it);
    endtask

    task automatic write_palette_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        palette_copy[idx] = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic write_random_palette();
        write_palette_reg(CFG_PAL_0_TO_3, {$urandom, $urandom});
        write_palette_reg(CFG_PAL_4_TO_7, {$urandom, $urandom});
        write_palette_reg(CFG_PAL_8_TO_11, {$urandom, $urandom});
        write_palette_reg(CFG_PAL_12_TO_15, {$urandom, $urandom});
    endtask

    // Wait until every item went in and every result came out, then let the pipe settle
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || s_axis_tvalid || expected_texels.size() != 0);
        repeat (PIPE_LATENCY + 2) @(negedge clk);
    endtask

    // Random stream continuing the current icon, with an occasional restart
    task automatic queue_random_run(int count);
        for (int i = 0; i < count; i++)
            queue_item(8'($urandom_range(0, 255)), ($urandom_range(0, 39) == 0));
    endtask

    // Stimulus and end of run
    initial
    begin
        for (int i = 0; i < 4; i++)
            palette_copy[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Reset palette: everything black, only alpha varies
        queue_item(8'hFF, 1'b1);
        queue_item(8'h00, 1'b0);
        queue_item(8'h81, 1'b0);
        wait_drained();

        // Extreme palette words; bit 15 of each entry set in the all-ones word
        write_palette_reg(CFG_PAL_0_TO_3, {CFG_DATA_W{1'b1}});
        write_palette_reg(CFG_PAL_4_TO_7, '0);
        write_palette_reg(CFG_PAL_8_TO_11, {16{4'h5}});
        write_palette_reg(CFG_PAL_12_TO_15, {16{4'hA}});

        // Every index on at least one side, nibble extremes, restarts mid-icon
        queue_item(8'h10, 1'b1);
        queue_item(8'h32, 1'b0);
        queue_item(8'h54, 1'b0);
        queue_item(8'h76, 1'b0);
        queue_item(8'h98, 1'b0);
        queue_item(8'hBA, 1'b0);
        queue_item(8'hDC, 1'b0);
        queue_item(8'hFE, 1'b0);
        queue_item(8'h0F, 1'b0);
        queue_item(8'hF0, 1'b0);
        queue_item(8'h00, 1'b0);
        queue_item(8'hFF, 1'b0);
        queue_item(8'h5A, 1'b1);
        queue_item(8'hA5, 1'b0);
        queue_item(8'h3C, 1'b1);
        queue_item(8'hC3, 1'b1);
        wait_drained();

        // One whole icon from a restart, ending on the last byte
        write_random_palette();
        queue_item(8'($urandom_range(0, 255)), 1'b1);
        for (int i = 1; i < 512; i++)
            queue_item(8'($urandom_range(0, 255)), 1'b0);
        long_stall_req = 1'b1;
        wait_drained();

        // Counter wraps into the next icon without a restart
        write_palette_reg(CFG_PAL_0_TO_3, {CFG_DATA_W{1'b1}});
        write_palette_reg(CFG_PAL_4_TO_7, {CFG_DATA_W{1'b1}});
        write_palette_reg(CFG_PAL_8_TO_11, {CFG_DATA_W{1'b1}});
        write_palette_reg(CFG_PAL_12_TO_15, {CFG_DATA_W{1'b1}});
        queue_random_run(220);
        wait_drained();

        write_random_palette();
        queue_random_run(220);
        wait_drained();

        if (mismatch_count == 0 && expected_texels.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
